FILE: hdl/ptpd_pkg.sv
// shared types and constants of the stream predictor decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ptpd_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH         = 2;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [3:0]  MODE_RST    = 4'd1;
  localparam logic [3:0]  MODE_TIFF   = 4'd2;
  localparam logic [3:0]  MODE_PNG_LO = 4'd10;
  localparam logic [12:0] COLUMNS_RST = 13'd1;
  localparam logic [2:0]  COLORS_RST  = 3'd1;
  localparam logic [4:0]  BPC_RST     = 5'd8;
  localparam logic [4:0]  BPC_TIFF    = 5'd8;

  // png row tag codes
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_SUB,
    OP_UP,
    OP_AVG,
    OP_PAETH
  } op_t;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_COLUMNS,
    REG_COLORS,
    REG_BPC
  } reg_idx_t;

  // per-item control passed from front to back
  typedef struct packed {
    op_t  op;
    logic last;
    logic past_step;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

`default_nettype wire

FILE: hdl/png_tiff_predictor_decoder_top.sv
// path: an accepted data byte passes through the queue, the read stage and the output register;
// png row tags are consumed and give no output
// throughput: one byte per cycle while no stall is raised on either side, set by
// the registered line store read and the left-byte feedback through the back end
// reset: line store needs no clearing pass (a fill count marks written bytes);
// input stalls after reset and after each register write until the slot position is rebuilt
`timescale 1ns / 1ps
`default_nettype none

module png_tiff_predictor_decoder_top
  import ptpd_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   row_last
);

  localparam int COL_W  = $clog2(MAX_ROW_BYTES);
  localparam int RLEN_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int STEP_W = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int Q_W    = CTL_W + 8 + COL_W + SLOT_W;

  logic [3:0]  predictor_mode;
  logic [12:0] columns;
  logic [2:0]  colors;
  logic [4:0]  bits_per_component;

  logic        cfg_wr;
  reg_idx_t    wr_idx;
  reg_idx_t    rd_idx;

  logic [7:0]        comp_bits;
  logic [20:0]       row_bits;
  logic [18:0]       row_bytes;
  logic [5:0]        pix_bytes;
  logic [RLEN_W-1:0] rlen;
  logic [STEP_W-1:0] step;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  ctl_t              f_ctl;
  logic [7:0]        f_data;
  logic [COL_W-1:0]  f_col;
  logic [SLOT_W-1:0] f_slot;
  ctl_t              b_ctl;
  logic [7:0]        b_data;
  logic [COL_W-1:0]  b_col;
  logic [SLOT_W-1:0] b_slot;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign rd_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_mode     <= MODE_RST;
      columns            <= COLUMNS_RST;
      colors             <= COLORS_RST;
      bits_per_component <= BPC_RST;
    end else if (cfg_wr) begin
      unique case (wr_idx)
        REG_MODE:    predictor_mode     <= pwdata[3:0];
        REG_COLUMNS: columns            <= pwdata[12:0];
        REG_COLORS:  colors             <= pwdata[2:0];
        REG_BPC:     bits_per_component <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (rd_idx)
      REG_MODE:    prdata = APB_DW'(predictor_mode);
      REG_COLUMNS: prdata = APB_DW'(columns);
      REG_COLORS:  prdata = APB_DW'(colors);
      REG_BPC:     prdata = APB_DW'(bits_per_component);
    endcase
  end

  // row length and pixel step, registered after each multiply
  assign row_bits  = 21'(columns) * 21'(comp_bits);
  assign row_bytes = 19'((22'(row_bits) + 22'd7) >> 3);
  assign pix_bytes = 6'((9'(comp_bits) + 9'd7) >> 3);

  always_ff @(posedge clk) begin
    comp_bits <= 8'(colors) * 8'(bits_per_component);
    if (row_bytes == '0) begin
      rlen <= RLEN_W'(1);
    end else if (row_bytes > 19'(MAX_ROW_BYTES)) begin
      rlen <= RLEN_W'(MAX_ROW_BYTES);
    end else begin
      rlen <= RLEN_W'(row_bytes);
    end
    if (pix_bytes == '0) begin
      step <= STEP_W'(1);
    end else if (pix_bytes > 6'(MAX_PIXEL_BYTES)) begin
      step <= STEP_W'(MAX_PIXEL_BYTES);
    end else begin
      step <= STEP_W'(pix_bytes);
    end
  end

  ptpd_front #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte (in_byte),
    .cfg_wr  (cfg_wr),
    .mode    (predictor_mode),
    .bpc     (bits_per_component),
    .rlen    (rlen),
    .step    (step),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_ctl   (f_ctl),
    .q_data  (f_data),
    .q_col   (f_col),
    .q_slot  (f_slot)
  );

  ptpd_fifo #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata({f_ctl, f_data, f_col, f_slot}),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata({b_ctl, b_data, b_col, b_slot})
  );

  ptpd_back #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_ctl    (b_ctl),
    .q_data   (b_data),
    .q_col    (b_col),
    .q_slot   (b_slot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .row_last (row_last)
  );

  // queue must never be written while full
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("item pushed into a full queue");

  // input must hold off while the slot position is rebuilt after a write
  assert property (@(posedge clk) disable iff (rst) cfg_wr |=> in_stall)
    else $error("input taken right after a register write");

endmodule

`default_nettype wire

FILE: hdl/ptpd_fifo.sv
// small show-ahead queue between the front and the back end
// depends on ptpd_pkg for the queue depth
`timescale 1ns / 1ps
`default_nettype none

module ptpd_fifo
  import ptpd_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ptpd_front.sv
// front end: takes input items, consumes png row tags, tracks row position
// and pixel slot, classifies each data byte; depends on ptpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpd_front
  import ptpd_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  localparam int COL_W  = $clog2(MAX_ROW_BYTES),
  localparam int RLEN_W = $clog2(MAX_ROW_BYTES + 1),
  localparam int STEP_W = $clog2(MAX_PIXEL_BYTES + 1),
  localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  input  wire logic              cfg_wr,
  input  wire logic [3:0]        mode,
  input  wire logic [4:0]        bpc,
  input  wire logic [RLEN_W-1:0] rlen,
  input  wire logic [STEP_W-1:0] step,
  input  wire logic              q_full,
  output logic                   q_push,
  output ctl_t                   q_ctl,
  output logic [7:0]             q_data,
  output logic [COL_W-1:0]       q_col,
  output logic [SLOT_W-1:0]      q_slot
);

  localparam int CNT_W = $clog2(COL_W);

  logic [COL_W-1:0]  byte_column;
  logic [SLOT_W-1:0] slot;
  logic [7:0]        row_filter;
  logic              expect_tag;

  logic              wr_d1;
  logic              wr_d2;
  logic              mod_busy;
  logic [CNT_W-1:0]  mod_cnt;
  logic [STEP_W-1:0] mod_rem;
  logic [STEP_W:0]   mod_trial;
  logic [STEP_W-1:0] mod_rem_next;

  logic              png;
  logic              tag;
  logic              accept;
  logic [RLEN_W-1:0] col_inc;
  logic              last;
  logic              slot_wrap;
  op_t               op;

  assign png     = (mode >= MODE_PNG_LO);
  assign tag     = png && expect_tag;
  assign in_stall = q_full || cfg_wr || wr_d1 || wr_d2 || mod_busy;
  assign accept  = in_valid && !in_stall;
  assign col_inc = RLEN_W'(byte_column) + RLEN_W'(1);
  assign last    = (col_inc >= rlen);
  assign slot_wrap = ((STEP_W'(slot) + STEP_W'(1)) == step);

  // bit-serial remainder of the column by the pixel step, one bit per cycle
  assign mod_trial    = {mod_rem, byte_column[mod_cnt]};
  assign mod_rem_next = (mod_trial >= (STEP_W + 1)'(step))
                      ? STEP_W'(mod_trial - (STEP_W + 1)'(step))
                      : STEP_W'(mod_trial);

  always_comb begin
    op = OP_PASS;
    if (png) begin
      unique case (row_filter)
        FILT_SUB:   op = OP_SUB;
        FILT_UP:    op = OP_UP;
        FILT_AVG:   op = OP_AVG;
        FILT_PAETH: op = OP_PAETH;
        default:    op = OP_PASS;
      endcase
    end else if (mode == MODE_TIFF && bpc == BPC_TIFF) begin
      op = OP_SUB;
    end
  end

  assign q_push          = accept && !tag;
  assign q_ctl.op        = op;
  assign q_ctl.last      = last;
  assign q_ctl.past_step = (RLEN_W'(byte_column) >= RLEN_W'(step));
  assign q_data          = in_byte;
  assign q_col           = byte_column;
  assign q_slot          = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      slot        <= '0;
      row_filter  <= FILT_NONE;
      expect_tag  <= 1'b1;
      wr_d1       <= 1'b1;
      wr_d2       <= 1'b1;
      mod_busy    <= 1'b0;
      mod_cnt     <= '0;
      mod_rem     <= '0;
    end else begin
      wr_d1 <= cfg_wr;
      wr_d2 <= wr_d1;
      // derived sizes settle after a write (tracked by wr_d1 and wr_d2), then the slot is rebuilt
      if (wr_d2) begin
        mod_busy <= 1'b1;
        mod_cnt  <= CNT_W'(COL_W - 1);
        mod_rem  <= '0;
      end else if (mod_busy) begin
        mod_rem <= mod_rem_next;
        if (mod_cnt == '0) begin
          mod_busy <= 1'b0;
          slot     <= SLOT_W'(mod_rem_next);
        end else begin
          mod_cnt <= mod_cnt - CNT_W'(1);
        end
      end

      if (accept) begin
        if (tag) begin
          row_filter  <= in_byte;
          expect_tag  <= 1'b0;
          byte_column <= '0;
          slot        <= '0;
        end else if (last) begin
          byte_column <= '0;
          slot        <= '0;
          expect_tag  <= 1'b1;
        end else begin
          byte_column <= COL_W'(col_inc);
          slot        <= slot_wrap ? '0 : slot + SLOT_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ptpd_back.sv
// back end: line store read, filter arithmetic, history update, output register
// depends on ptpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpd_back
  import ptpd_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  localparam int COL_W  = $clog2(MAX_ROW_BYTES),
  localparam int RLEN_W = $clog2(MAX_ROW_BYTES + 1),
  localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire ctl_t              q_ctl,
  input  wire logic [7:0]        q_data,
  input  wire logic [COL_W-1:0]  q_col,
  input  wire logic [SLOT_W-1:0] q_slot,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   row_last
);

  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] left_hist [MAX_PIXEL_BYTES];
  logic [7:0] upper_hist [MAX_PIXEL_BYTES];
  logic [RLEN_W-1:0] fill;

  // read stage
  logic              a_valid;
  ctl_t              a_ctl;
  logic [7:0]        a_data;
  logic [COL_W-1:0]  a_col;
  logic [SLOT_W-1:0] a_slot;
  logic [7:0]        a_rdata;
  logic              a_fwd;
  logic [7:0]        a_fwd_val;
  logic              a_inrange;

  logic              retire;
  logic [7:0]        left_a;
  logic [7:0]        up_b;
  logic [7:0]        ul_c;
  logic [8:0]        avg_sum;
  logic signed [9:0] p;
  logic signed [9:0] q;
  logic signed [9:0] pq;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;
  logic [7:0]        pred;
  logic [7:0]        res;

  assign retire = a_valid && (!out_valid || !out_stall);
  assign q_pop  = q_valid && (!a_valid || retire);

  assign left_a = a_ctl.past_step ? left_hist[a_slot] : 8'd0;
  assign ul_c   = a_ctl.past_step ? upper_hist[a_slot] : 8'd0;
  // entries beyond the fill count were never written and read as zero
  assign up_b   = a_fwd ? a_fwd_val : (a_inrange ? a_rdata : 8'd0);

  assign avg_sum = 9'(left_a) + 9'(up_b);
  assign p  = $signed({2'b00, up_b}) - $signed({2'b00, ul_c});
  assign q  = $signed({2'b00, left_a}) - $signed({2'b00, ul_c});
  assign pq = p + q;
  assign pa = p[9]  ? $unsigned(-p)  : $unsigned(p);
  assign pb = q[9]  ? $unsigned(-q)  : $unsigned(q);
  assign pc = pq[9] ? $unsigned(-pq) : $unsigned(pq);

  always_comb begin
    if (pa <= pb && pa <= pc) begin
      paeth = left_a;
    end else if (pb <= pc) begin
      paeth = up_b;
    end else begin
      paeth = ul_c;
    end
  end

  always_comb begin
    unique case (a_ctl.op)
      OP_SUB:   pred = left_a;
      OP_UP:    pred = up_b;
      OP_AVG:   pred = avg_sum[8:1];
      OP_PAETH: pred = paeth;
      default:  pred = 8'd0;
    endcase
  end

  assign res = a_data + pred;

  // line store: written on retire, read when the next item enters the read stage
  always_ff @(posedge clk) begin
    if (retire) begin
      line_mem[a_col] <= res;
    end
    if (q_pop) begin
      a_rdata <= line_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_ctl     <= q_ctl;
      a_data    <= q_data;
      a_col     <= q_col;
      a_slot    <= q_slot;
      // same-address write in this cycle beats the array read
      a_fwd     <= retire && (a_col == q_col);
      a_fwd_val <= res;
      a_inrange <= (RLEN_W'(q_col) < fill);
    end
    if (retire) begin
      out_byte <= res;
      row_last <= a_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      fill      <= '0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]  <= 8'd0;
        upper_hist[i] <= 8'd0;
      end
    end else begin
      if (q_pop) begin
        a_valid <= 1'b1;
      end else if (retire) begin
        a_valid <= 1'b0;
      end

      if (retire) begin
        out_valid         <= 1'b1;
        left_hist[a_slot]  <= res;
        upper_hist[a_slot] <= up_b;
        if (RLEN_W'(a_col) >= fill) begin
          fill <= RLEN_W'(a_col) + RLEN_W'(1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
